@@ rtl/cfp_pkg.sv @@
`timescale 1ns / 1ps
// cfp_pkg: types, codes and constants shared by the command frame parser
// no dependencies; compiled first

package cfp_pkg;

  // frames shorter than this are reported short
  localparam int unsigned MIN_FRAME_BYTES = 13;
  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // parse phase of the front end
  typedef enum logic [3:0] {
    PH_PRIO    = 4'd0,
    PH_INDEX   = 4'd1,
    PH_LABEL   = 4'd2,
    PH_SRC     = 4'd3,
    PH_DST     = 4'd4,
    PH_TAG     = 4'd5,
    PH_LENHEAD = 4'd6,
    PH_LENEXT  = 4'd7,
    PH_PAYLOAD = 4'd8,
    PH_SURPLUS = 4'd9
  } phase_t;

  // byte kinds
  localparam logic [3:0] KIND_PRIO    = 4'd0;
  localparam logic [3:0] KIND_INDEX   = 4'd1;
  localparam logic [3:0] KIND_LABEL   = 4'd2;
  localparam logic [3:0] KIND_SRC     = 4'd3;
  localparam logic [3:0] KIND_DST     = 4'd4;
  localparam logic [3:0] KIND_TAG     = 4'd5;
  localparam logic [3:0] KIND_LENGTH  = 4'd6;
  localparam logic [3:0] KIND_PAYLOAD = 4'd7;
  localparam logic [3:0] KIND_SURPLUS = 4'd8;

  // frame status codes
  localparam logic [2:0] STATUS_OK         = 3'd0;
  localparam logic [2:0] STATUS_SHORT      = 3'd1;
  localparam logic [2:0] STATUS_NO_SRC_END = 3'd2;
  localparam logic [2:0] STATUS_NO_DST_END = 3'd3;
  localparam logic [2:0] STATUS_SHORT_TAG  = 3'd4;
  localparam logic [2:0] STATUS_BAD_PREFIX = 3'd5;
  localparam logic [2:0] STATUS_MISMATCH   = 3'd6;

  // length field prefix bytes
  localparam logic [7:0] LEN_LONG_BIT = 8'h80;
  localparam logic [6:0] LEN_FORM_ONE = 7'd1;
  localparam logic [6:0] LEN_FORM_TWO = 7'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  byte_kind;
    logic [7:0]  byte_value;
    logic        frame_done;
    logic [2:0]  frame_status;
    logic [7:0]  priority_res;
    logic [15:0] message_index;
    logic [15:0] message_label;
    logic [31:0] message_tag;
    logic [15:0] payload_length;
  } out_item_t;

  // one classified beat handed from front to back
  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  value;
    logic        last;
    logic [1:0]  tag_lane;     // byte position inside the tag
    logic [2:0]  status;       // status of the frame, short check aside
    logic [15:0] plen;         // reported payload length
  } cfp_entry_t;

endpackage

@@ rtl/cfp_stream_if.sv @@
`timescale 1ns / 1ps
// cfp_stream_if: valid/ready channel carrying one item per beat
// item type given by parameter; used for both ports of the parser

interface cfp_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/command_frame_parser.sv @@
`timescale 1ns / 1ps
// command_frame_parser: top level of the streaming command frame parser
// depends on cfp_pkg, cfp_stream_if, cfp_front, cfp_queue and cfp_back

// Takes one frame byte per beat on frame_bytes (frame_end marks the last
// byte) and returns exactly one result beat per byte on byte_results: the
// byte's kind (priority, index, label, source, dest, tag, length, payload or
// surplus) and the byte itself. On the result for the last byte the decoded
// priority, big-endian index and label, little-endian tag, declared payload
// length and a frame status are reported; on other beats these are zero.
// The parser takes one byte every cycle while the queue is not full; a byte's
// result beat is offered once it reaches the output register (the classified
// byte lands in the queue at the accepting edge, the output register loads
// from the queue when it is empty or its beat is being taken); a stall on
// byte_results delays it further. The classifier and the field assembler are parted
// by a queue of QUEUE_DEPTH beats, so input is still taken while a finished
// result waits, until the queue fills; a byte offered while the queue is full
// waits until a result is taken and the queue has drained a slot.

module command_frame_parser #(
  parameter int unsigned QUEUE_DEPTH = cfp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  cfp_stream_if.sink   frame_bytes,
  cfp_stream_if.source byte_results
);
  import cfp_pkg::*;

  // front to back hand-off
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  cfp_entry_t push_entry;
  cfp_entry_t head;

  // front end: phase tracking, byte classification, length decode, status
  cfp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_bytes (frame_bytes),
    .full        (full),
    .push        (push),
    .entry       (push_entry)
  );

  // short queue so front and back stall independently
  cfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  // back end: header assembly, minimum size check, output register
  cfp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .byte_results (byte_results)
  );

`ifndef ASSERT_OFF
  // front never writes into a full queue
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue written while full");

  // back never reads an empty queue
  a_no_underflow : assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue read while empty");

  // status, tag and payload length only on the last beat of a frame
  a_quiet_header : assert property (@(posedge clk) disable iff (rst)
    (byte_results.valid && !byte_results.payload.frame_done) |->
      (byte_results.payload.frame_status == STATUS_OK &&
       byte_results.payload.message_tag == 32'd0 &&
       byte_results.payload.payload_length == 16'd0))
    else $error("header reported on a beat that does not end a frame");

  // a frame's first byte is always classified as priority
  a_prio_first : assert property (@(posedge clk) disable iff (rst)
    (push && push_entry.last) |=> (!push || push_entry.kind == KIND_PRIO))
    else $error("byte after frame end not classified as priority");
`endif

endmodule

@@ rtl/cfp_queue.sv @@
`timescale 1ns / 1ps
// cfp_queue: small register queue between parser front and back
// depends on cfp_pkg for the entry type

module cfp_queue #(
  parameter int unsigned DEPTH = cfp_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cfp_pkg::cfp_entry_t push_entry,
  input  logic                pop,
  output cfp_pkg::cfp_entry_t head,
  output logic                full,
  output logic                empty
);
  import cfp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cfp_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head  = slots[rd_ptr];
  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/cfp_front.sv @@
`timescale 1ns / 1ps
// cfp_front: accepts frame beats, tracks the parse phase and classifies bytes
// depends on cfp_pkg and cfp_stream_if; feeds cfp_queue

module cfp_front (
  input  logic                clk,
  input  logic                rst,
  cfp_stream_if.sink          frame_bytes,
  input  logic                full,
  output logic                push,
  output cfp_pkg::cfp_entry_t entry
);
  import cfp_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  logic [1:0]  fcount;
  logic [1:0]  fcount_next;
  logic [1:0]  length_form;
  logic [1:0]  length_form_next;
  logic [15:0] declared_length;
  logic [15:0] declared_length_next;
  logic [15:0] payload_remaining;
  logic [15:0] payload_remaining_next;
  logic [2:0]  error_code;
  logic [2:0]  error_code_next;

  logic [7:0]  b;
  logic        last;
  logic [6:0]  low7;
  logic        form_ok;
  logic [1:0]  fc_inc;
  logic [15:0] decl_shift;
  logic [15:0] rem_dec;

  assign frame_bytes.ready = !full;
  assign push = frame_bytes.valid && !full;
  assign b    = frame_bytes.payload.data_byte;
  assign last = frame_bytes.payload.frame_end;

  assign low7       = b[6:0];
  assign form_ok    = (low7 == LEN_FORM_ONE) || (low7 == LEN_FORM_TWO);
  assign fc_inc     = fcount + 2'd1;
  assign decl_shift = {declared_length[7:0], b};
  assign rem_dec    = (payload_remaining != '0) ? payload_remaining - 16'd1
                                                : payload_remaining;

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_PRIO:  phase_next = PH_INDEX;
      PH_INDEX: begin
        if (fcount == 2'd1) phase_next = PH_LABEL;
      end
      PH_LABEL: begin
        if (fcount == 2'd1) phase_next = PH_SRC;
      end
      PH_SRC: begin
        if (b == 8'd0) phase_next = PH_DST;
      end
      PH_DST: begin
        if (b == 8'd0) phase_next = PH_TAG;
      end
      PH_TAG: begin
        if (fcount == 2'd3) phase_next = PH_LENHEAD;
      end
      PH_LENHEAD: begin
        if ((b & LEN_LONG_BIT) == 8'd0) begin
          phase_next = ({9'd0, low7} != 16'd0) ? PH_PAYLOAD : PH_SURPLUS;
        end else if (form_ok) begin
          phase_next = PH_LENEXT;
        end else begin
          phase_next = PH_SURPLUS;
        end
      end
      PH_LENEXT: begin
        if (fc_inc >= length_form) begin
          phase_next = (decl_shift != 16'd0) ? PH_PAYLOAD : PH_SURPLUS;
        end
      end
      PH_PAYLOAD: begin
        if (rem_dec == 16'd0) phase_next = PH_SURPLUS;
      end
      default: phase_next = PH_SURPLUS;
    endcase
  end

  // per-beat outputs and datapath updates
  always_comb begin
    fcount_next            = fcount;
    length_form_next       = length_form;
    declared_length_next   = declared_length;
    payload_remaining_next = payload_remaining;
    error_code_next        = error_code;
    entry.kind             = KIND_SURPLUS;
    entry.value            = b;
    entry.last             = last;
    entry.tag_lane         = fcount;
    case (phase)
      PH_PRIO: begin
        entry.kind  = KIND_PRIO;
        fcount_next = 2'd0;
      end
      PH_INDEX: begin
        entry.kind  = KIND_INDEX;
        fcount_next = (fcount == 2'd1) ? 2'd0 : 2'd1;
      end
      PH_LABEL: begin
        entry.kind  = KIND_LABEL;
        fcount_next = (fcount == 2'd1) ? 2'd0 : 2'd1;
      end
      PH_SRC: entry.kind = KIND_SRC;
      PH_DST: begin
        entry.kind = KIND_DST;
        if (b == 8'd0) fcount_next = 2'd0;
      end
      PH_TAG: begin
        entry.kind  = KIND_TAG;
        fcount_next = fc_inc;
      end
      PH_LENHEAD: begin
        entry.kind = KIND_LENGTH;
        if ((b & LEN_LONG_BIT) == 8'd0) begin
          length_form_next       = 2'd0;
          declared_length_next   = {9'd0, low7};
          payload_remaining_next = {9'd0, low7};
        end else if (form_ok) begin
          length_form_next     = low7[1:0];
          declared_length_next = 16'd0;
          fcount_next          = 2'd0;
        end else begin
          error_code_next = STATUS_BAD_PREFIX;
        end
      end
      PH_LENEXT: begin
        entry.kind           = KIND_LENGTH;
        declared_length_next = decl_shift;
        fcount_next          = fc_inc;
        if (fc_inc >= length_form) payload_remaining_next = decl_shift;
      end
      PH_PAYLOAD: begin
        entry.kind             = KIND_PAYLOAD;
        payload_remaining_next = rem_dec;
      end
      default: begin
        entry.kind = KIND_SURPLUS;
        if (error_code == STATUS_OK) error_code_next = STATUS_MISMATCH;
      end
    endcase

    // status from a recorded error, else from the phase the frame ends in
    if (error_code_next != STATUS_OK) begin
      entry.status = error_code_next;
    end else begin
      case (phase_next)
        PH_PRIO, PH_INDEX, PH_LABEL, PH_SRC: entry.status = STATUS_NO_SRC_END;
        PH_DST:     entry.status = STATUS_NO_DST_END;
        PH_TAG:     entry.status = STATUS_SHORT_TAG;
        PH_SURPLUS: entry.status = STATUS_OK;
        default:    entry.status = STATUS_MISMATCH;
      endcase
    end
    entry.plen = (error_code_next == STATUS_BAD_PREFIX) ? 16'd0 : declared_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_PRIO;
      fcount            <= '0;
      length_form       <= '0;
      declared_length   <= '0;
      payload_remaining <= '0;
      error_code        <= STATUS_OK;
    end else if (push) begin
      if (last) begin
        phase             <= PH_PRIO;
        fcount            <= '0;
        length_form       <= '0;
        declared_length   <= '0;
        payload_remaining <= '0;
        error_code        <= STATUS_OK;
      end else begin
        phase             <= phase_next;
        fcount            <= fcount_next;
        length_form       <= length_form_next;
        declared_length   <= declared_length_next;
        payload_remaining <= payload_remaining_next;
        error_code        <= error_code_next;
      end
    end
  end

endmodule

@@ rtl/cfp_back.sv @@
`timescale 1ns / 1ps
// cfp_back: assembles header fields, applies the size check, drives results
// depends on cfp_pkg and cfp_stream_if; drains cfp_queue

module cfp_back (
  input  logic                clk,
  input  logic                rst,
  input  cfp_pkg::cfp_entry_t head,
  input  logic                empty,
  output logic                pop,
  cfp_stream_if.source        byte_results
);
  import cfp_pkg::*;

  localparam logic [3:0] MIN_BYTES = 4'(MIN_FRAME_BYTES);
  localparam logic [3:0] SAT_MAX   = 4'd15;

  logic [3:0]  total_bytes;
  logic [3:0]  total_bytes_next;
  logic [7:0]  priority_reg;
  logic [7:0]  priority_next;
  logic [15:0] index_reg;
  logic [15:0] index_next;
  logic [15:0] label_reg;
  logic [15:0] label_next;
  logic [31:0] tag_reg;
  logic [31:0] tag_next;
  out_item_t   result_next;
  logic        out_valid;
  out_item_t   out_item;

  assign pop = !empty && (!out_valid || byte_results.ready);
  assign byte_results.valid   = out_valid;
  assign byte_results.payload = out_item;

  always_comb begin
    total_bytes_next = (total_bytes < SAT_MAX) ? total_bytes + 4'd1 : total_bytes;
    priority_next    = priority_reg;
    index_next       = index_reg;
    label_next       = label_reg;
    tag_next         = tag_reg;
    case (head.kind)
      KIND_PRIO:  priority_next = head.value;
      KIND_INDEX: index_next    = {index_reg[7:0], head.value};
      KIND_LABEL: label_next    = {label_reg[7:0], head.value};
      KIND_TAG:   tag_next      = tag_reg | ({24'd0, head.value} << {head.tag_lane, 3'b000});
      default:    ;
    endcase

    result_next            = '0;
    result_next.byte_kind  = head.kind;
    result_next.byte_value = head.value;
    result_next.frame_done = head.last;
    if (head.last) begin
      result_next.frame_status   = (total_bytes_next < MIN_BYTES) ? STATUS_SHORT
                                                                   : head.status;
      result_next.priority_res   = priority_next;
      result_next.message_index  = index_next;
      result_next.message_label  = label_next;
      result_next.message_tag    = tag_next;
      result_next.payload_length = head.plen;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      total_bytes  <= '0;
      priority_reg <= '0;
      index_reg    <= '0;
      label_reg    <= '0;
      tag_reg      <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (byte_results.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (head.last) begin
          total_bytes  <= '0;
          priority_reg <= '0;
          index_reg    <= '0;
          label_reg    <= '0;
          tag_reg      <= '0;
        end else begin
          total_bytes  <= total_bytes_next;
          priority_reg <= priority_next;
          index_reg    <= index_next;
          label_reg    <= label_next;
          tag_reg      <= tag_next;
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_command_frame_parser.sv @@
`timescale 1ns / 1ps
// tb_command_frame_parser: self-checking bench for the command frame parser
// depends on cfp_pkg, cfp_stream_if and the command_frame_parser rtl

module tb_command_frame_parser;
  import cfp_pkg::*;

  // generous cycle budget, well above what a correct run needs
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned RANDOM_BEATS = 800;

  // one stimulus row: the byte beat, plus a hand-typed result where the
  // outcome is obvious; all other rows are checked against the predictor
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic clk;
  logic rst;

  cfp_stream_if #(.item_t(in_item_t))  frame_bytes ();
  cfp_stream_if #(.item_t(out_item_t)) byte_results ();

  command_frame_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .frame_bytes  (frame_bytes),
    .byte_results (byte_results)
  );

  stim_row_t   stim_rows[$];
  out_item_t   expected_results[$];
  int unsigned errors;
  int unsigned beats_seen;
  int unsigned cycles;

  // ------------------------------------------------------------------
  // frame parse predictor: its own copy of the per-frame state
  // ------------------------------------------------------------------
  phase_t      cur_phase;
  logic [1:0]  fld_cnt;
  logic [3:0]  byte_tally;     // saturates at fifteen
  logic [7:0]  prio_acc;
  logic [15:0] index_acc;
  logic [15:0] label_acc;
  logic [31:0] tag_acc;
  logic [1:0]  len_form;
  logic [15:0] plen_acc;
  logic [16:0] pay_left;
  logic [2:0]  err_acc;

  function automatic void clear_parse();
    cur_phase  = PH_PRIO;
    fld_cnt    = '0;
    byte_tally = '0;
    prio_acc   = '0;
    index_acc  = '0;
    label_acc  = '0;
    tag_acc    = '0;
    len_form   = '0;
    plen_acc   = '0;
    pay_left   = '0;
    err_acc    = STATUS_OK;
  endfunction

  // length field complete: payload if any was declared, else straight to surplus
  function automatic void start_payload();
    pay_left  = {1'b0, plen_acc};
    cur_phase = (pay_left != 0) ? PH_PAYLOAD : PH_SURPLUS;
  endfunction

  function automatic out_item_t classify_byte(in_item_t it);
    out_item_t  r;
    logic [7:0] b;
    logic [2:0] st;
    b = it.data_byte;
    r = '0;
    r.byte_kind = KIND_SURPLUS;
    if (byte_tally < 4'd15) byte_tally++;
    case (cur_phase)
      PH_PRIO: begin
        r.byte_kind = KIND_PRIO;
        prio_acc    = b;
        cur_phase   = PH_INDEX;
        fld_cnt     = '0;
      end
      PH_INDEX: begin
        r.byte_kind = KIND_INDEX;
        index_acc   = {index_acc[7:0], b};
        if (fld_cnt == 2'd1) begin
          cur_phase = PH_LABEL;
          fld_cnt   = '0;
        end else begin
          fld_cnt = 2'd1;
        end
      end
      PH_LABEL: begin
        r.byte_kind = KIND_LABEL;
        label_acc   = {label_acc[7:0], b};
        if (fld_cnt == 2'd1) begin
          cur_phase = PH_SRC;
          fld_cnt   = '0;
        end else begin
          fld_cnt = 2'd1;
        end
      end
      PH_SRC: begin
        r.byte_kind = KIND_SRC;
        if (b == 8'd0) cur_phase = PH_DST;
      end
      PH_DST: begin
        r.byte_kind = KIND_DST;
        if (b == 8'd0) begin
          cur_phase = PH_TAG;
          fld_cnt   = '0;
        end
      end
      PH_TAG: begin
        // little-endian: first tag byte lands in the low lane
        r.byte_kind = KIND_TAG;
        tag_acc     = tag_acc | (32'(b) << (8 * fld_cnt));
        if (fld_cnt == 2'd3) begin
          cur_phase = PH_LENHEAD;
          fld_cnt   = '0;
        end else begin
          fld_cnt++;
        end
      end
      PH_LENHEAD: begin
        r.byte_kind = KIND_LENGTH;
        if ((b & LEN_LONG_BIT) == 8'd0) begin
          len_form = '0;
          plen_acc = {9'd0, b[6:0]};
          start_payload();
        end else if (b[6:0] == LEN_FORM_ONE || b[6:0] == LEN_FORM_TWO) begin
          len_form  = b[1:0];
          plen_acc  = '0;
          fld_cnt   = '0;
          cur_phase = PH_LENEXT;
        end else begin
          // unknown long-form prefix: rest of frame is surplus
          err_acc   = STATUS_BAD_PREFIX;
          cur_phase = PH_SURPLUS;
        end
      end
      PH_LENEXT: begin
        r.byte_kind = KIND_LENGTH;
        plen_acc    = {plen_acc[7:0], b};
        fld_cnt++;
        if (fld_cnt >= len_form) start_payload();
      end
      PH_PAYLOAD: begin
        r.byte_kind = KIND_PAYLOAD;
        if (pay_left != 0) pay_left--;
        if (pay_left == 0) cur_phase = PH_SURPLUS;
      end
      default: begin
        // byte past the declared payload
        r.byte_kind = KIND_SURPLUS;
        if (err_acc == STATUS_OK) err_acc = STATUS_MISMATCH;
      end
    endcase
    r.byte_value = b;
    r.frame_done = it.frame_end;
    if (it.frame_end) begin
      // short wins, then a recorded error, then where the frame stopped
      if (byte_tally < MIN_FRAME_BYTES)  st = STATUS_SHORT;
      else if (err_acc != STATUS_OK)     st = err_acc;
      else if (cur_phase <= PH_SRC)      st = STATUS_NO_SRC_END;
      else if (cur_phase == PH_DST)      st = STATUS_NO_DST_END;
      else if (cur_phase == PH_TAG)      st = STATUS_SHORT_TAG;
      else if (cur_phase == PH_SURPLUS)  st = STATUS_OK;
      else                               st = STATUS_MISMATCH;
      r.frame_status   = st;
      r.priority_res   = prio_acc;
      r.message_index  = index_acc;
      r.message_label  = label_acc;
      r.message_tag    = tag_acc;
      r.payload_length = (err_acc == STATUS_BAD_PREFIX) ? 16'd0 : plen_acc;
      clear_parse();
    end
    return r;
  endfunction

  // ------------------------------------------------------------------
  // stimulus construction
  // ------------------------------------------------------------------
  function automatic out_item_t final_result(logic [3:0] kind, logic [7:0] value,
                                             logic [2:0] status, logic [7:0] prio,
                                             logic [15:0] idx, logic [15:0] lbl,
                                             logic [31:0] tag, logic [15:0] plen);
    out_item_t r;
    r.byte_kind      = kind;
    r.byte_value     = value;
    r.frame_done     = 1'b1;
    r.frame_status   = status;
    r.priority_res   = prio;
    r.message_index  = idx;
    r.message_label  = lbl;
    r.message_tag    = tag;
    r.payload_length = plen;
    return r;
  endfunction

  task automatic put_byte(logic [7:0] b, logic e);
    stim_row_t row;
    row.item.data_byte = b;
    row.item.frame_end = e;
    row.typed = 1'b0;
    row.want  = '0;
    stim_rows.push_back(row);
  endtask

  task automatic put_typed(logic [7:0] b, logic e, out_item_t want);
    stim_row_t row;
    row.item.data_byte = b;
    row.item.frame_end = e;
    row.typed = 1'b1;
    row.want  = want;
    stim_rows.push_back(row);
  endtask

  // one random frame: mostly well formed, some truncated, some with a bad
  // length prefix, a few pure noise
  task automatic gen_frame();
    logic [7:0]  fb[$];
    logic [15:0] dl;
    logic [7:0]  lh;
    int          mode, form, pay, cut, r, i;
    mode = $urandom_range(99);
    if (mode < 8) begin
      repeat ($urandom_range(1, 20)) fb.push_back(8'($urandom_range(255)));
    end else begin
      fb.push_back(8'($urandom_range(255)));                  // priority
      repeat (4) fb.push_back(8'($urandom_range(255)));       // index, label
      repeat ($urandom_range(0, 3)) fb.push_back(8'($urandom_range(1, 255)));
      fb.push_back(8'd0);                                     // source end
      repeat ($urandom_range(0, 3)) fb.push_back(8'($urandom_range(1, 255)));
      fb.push_back(8'd0);                                     // dest end
      repeat (4) fb.push_back(8'($urandom_range(255)));       // tag
      if (mode < 16) begin
        // long-form prefix with a form other than one or two
        lh = ($urandom_range(1) == 0) ? LEN_LONG_BIT
                                      : {1'b1, 7'($urandom_range(3, 127))};
        fb.push_back(lh);
        repeat ($urandom_range(0, 3)) fb.push_back(8'($urandom_range(255)));
      end else begin
        form = $urandom_range(2);
        r    = $urandom_range(9);
        case (form)
          0: dl = (r == 0) ? 16'd127 : 16'($urandom_range(0, 8));
          1: dl = (r == 0) ? 16'd255 : 16'($urandom_range(0, 8));
          default: begin
            if (r == 0) dl = ($urandom_range(1) == 0) ? 16'hFFFF
                                                      : 16'($urandom_range(256, 65535));
            else        dl = 16'($urandom_range(0, 8));
          end
        endcase
        if (form == 0) begin
          fb.push_back(dl[7:0]);
        end else if (form == 1) begin
          fb.push_back({1'b1, LEN_FORM_ONE});
          fb.push_back(dl[7:0]);
        end else begin
          fb.push_back({1'b1, LEN_FORM_TWO});
          fb.push_back(dl[15:8]);
          fb.push_back(dl[7:0]);
        end
        // big declared lengths only get a few payload bytes
        if (dl > 16) begin
          pay = $urandom_range(0, 6);
        end else begin
          pay = dl;
          r   = $urandom_range(99);
          if (r < 12)                pay = dl + 1;
          else if (r < 24 && dl > 0) pay = dl - 1;
        end
        repeat (pay) fb.push_back(8'($urandom_range(255)));
      end
      // cut the frame short somewhere
      if (mode >= 16 && mode < 30) begin
        cut = $urandom_range(1, fb.size());
        while (fb.size() > cut) fb.delete(fb.size() - 1);
      end
    end
    for (i = 0; i < fb.size(); i++) put_byte(fb[i], i == fb.size() - 1);
  endtask

  task automatic build_stimulus();
    int base;
    // lone byte right after reset: short frame, priority only
    put_typed(8'hFF, 1'b1, final_result(KIND_PRIO, 8'hFF, STATUS_SHORT, 8'hFF,
                                         16'h0000, 16'h0000, 32'h0, 16'h0));
    // minimum size frame with empty strings and a bad long-form prefix
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h83, 1'b0);
    put_typed(8'hFF, 1'b1, final_result(KIND_SURPLUS, 8'hFF, STATUS_BAD_PREFIX, 8'h00,
                                         16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 16'h0));
    // well formed frame with zero-length short-form length
    put_byte(8'h7F, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h01, 1'b0);
    put_byte(8'h80, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h01, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h78, 1'b0);
    put_byte(8'h56, 1'b0);
    put_byte(8'h34, 1'b0);
    put_byte(8'h12, 1'b0);
    put_typed(8'h00, 1'b1, final_result(KIND_LENGTH, 8'h00, STATUS_OK, 8'h7F,
                                         16'h0001, 16'h8000, 32'h1234_5678, 16'h0));
    base = stim_rows.size();
    while (stim_rows.size() < base + RANDOM_BEATS) gen_frame();
  endtask

  // ------------------------------------------------------------------
  // clock, reset, watchdog
  // ------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("command_frame_parser test failed");
    $finish;
  end

  // ------------------------------------------------------------------
  // result side: compare each taken beat with the oldest expectation
  // ------------------------------------------------------------------
  task automatic check_beat(out_item_t want, out_item_t got);
    if (got.byte_kind != want.byte_kind) begin
      $error("byte_kind: expected %0d, got %0d", want.byte_kind, got.byte_kind);
      errors++;
    end
    if (got.byte_value != want.byte_value) begin
      $error("byte_value: expected %0h, got %0h", want.byte_value, got.byte_value);
      errors++;
    end
    if (got.frame_done != want.frame_done) begin
      $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
      errors++;
    end
    if (got.frame_status != want.frame_status) begin
      $error("frame_status: expected %0d, got %0d", want.frame_status, got.frame_status);
      errors++;
    end
    if (got.priority_res != want.priority_res) begin
      $error("priority_res: expected %0h, got %0h", want.priority_res, got.priority_res);
      errors++;
    end
    if (got.message_index != want.message_index) begin
      $error("message_index: expected %0h, got %0h", want.message_index,
             got.message_index);
      errors++;
    end
    if (got.message_label != want.message_label) begin
      $error("message_label: expected %0h, got %0h", want.message_label,
             got.message_label);
      errors++;
    end
    if (got.message_tag != want.message_tag) begin
      $error("message_tag: expected %0h, got %0h", want.message_tag, got.message_tag);
      errors++;
    end
    if (got.payload_length != want.payload_length) begin
      $error("payload_length: expected %0h, got %0h", want.payload_length,
             got.payload_length);
      errors++;
    end
  endtask

  // values read right after the edge are the ones the edge sampled
  always @(posedge clk) begin
    if (rst === 1'b0 && byte_results.valid && byte_results.ready) begin
      beats_seen++;
      if (expected_results.size() == 0) begin
        $error("result beat with no byte waiting for it");
        errors++;
      end else begin
        check_beat(expected_results.pop_front(), byte_results.payload);
      end
    end
  end

  // result sink: random stalls, one long hold-off so the input backs up,
  // and a stretch of steady ready
  initial begin : result_sink
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    byte_results.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && beats_seen >= 200) begin
        held      = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        byte_results.ready <= 1'b0;
      end else if (beats_seen >= 450 && beats_seen < 600) begin
        byte_results.ready <= 1'b1;
      end else begin
        byte_results.ready <= ($urandom_range(99) >= 12);
      end
      @(posedge clk);
    end
  end

  // ------------------------------------------------------------------
  // byte source: walks the stimulus table, predicts each taken beat
  // ------------------------------------------------------------------
  initial begin : byte_source
    stim_row_t row;
    out_item_t pred;
    int        k;
    int        pause_at;
    bit        gap;
    errors     = 0;
    beats_seen = 0;
    clear_parse();
    frame_bytes.valid   <= 1'b0;
    frame_bytes.payload <= '0;
    build_stimulus();
    pause_at = stim_rows.size() - 100;
    @(posedge clk);
    while (rst) @(posedge clk);
    for (k = 0; k < stim_rows.size(); k++) begin
      row = stim_rows[k];
      // no gaps in one stretch of the table
      gap = (k < 300 || k >= 450) && ($urandom_range(99) < 12);
      if (k == pause_at) begin
        // drain: hold the next byte until every result is back
        frame_bytes.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
      end else if (gap) begin
        frame_bytes.valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      frame_bytes.valid   <= 1'b1;
      frame_bytes.payload <= row.item;
      do @(posedge clk); while (!frame_bytes.ready);
      pred = classify_byte(row.item);
      expected_results.push_back(row.typed ? row.want : pred);
    end
    frame_bytes.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // keep the clock running to catch any stray result beat
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("command_frame_parser test passed");
    end else begin
      $display("command_frame_parser test failed");
    end
    $finish;
  end

endmodule
